/* src/tmtw_pkg.sv */
// Shared types, codes and arithmetic helpers for the tempo map time warp block.
// Used by the top level and by the serial divider; depends on nothing else.
`timescale 1ns / 1ps

package tmtw_pkg;

    localparam int TIME_W       = 32;
    localparam int TEMPO_W      = 24;
    localparam int EXT_W        = 32;
    localparam int SCALE_W      = 24;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int DIV_W        = 48;
    localparam int DIV_CNT_W    = 6;
    localparam int MAX_POINTS_DEF = 16;

    localparam logic [TEMPO_W-1:0] ONE_TEMPO   = 24'h010000;
    localparam logic [TEMPO_W-1:0] TEMPO_LIMIT = 24'hFFFFFF;
    localparam logic [EXT_W-1:0]   WORD_LIMIT  = 32'hFFFFFFFF;

    localparam logic [SCALE_W-1:0] UNIT_SCALE_RESET    = 24'd4096;
    localparam logic [TEMPO_W-1:0] INITIAL_TEMPO_RESET = 24'd65536;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FORWARD = 2'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LAST      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TEMPO = 2'd1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [TEMPO_W-1:0] divisor;
    } div_req_t;

    function automatic logic [EXT_W-1:0] sat_word(input logic [63:0] v);
        sat_word = (v[63:32] != 32'd0) ? WORD_LIMIT : v[31:0];
    endfunction

    function automatic logic [TEMPO_W-1:0] clamp_tempo(input logic [DIV_W-1:0] q);
        logic [TEMPO_W-1:0] r;
        if (q[DIV_W-1:TEMPO_W] != '0) r = TEMPO_LIMIT;
        else if (q == '0)             r = 24'd1;
        else                          r = q[TEMPO_W-1:0];
        clamp_tempo = r;
    endfunction

    function automatic logic [EXT_W-1:0] scale_mul(input logic [TEMPO_W-1:0] t,
                                                   input logic [SCALE_W-2:0] s);
        logic [TEMPO_W+SCALE_W-2:0] p;
        p = t * s;
        scale_mul = sat_word(64'(p[TEMPO_W+SCALE_W-2:12]));
    endfunction

endpackage

/* src/tempo_map_time_warp_core.sv */
// Top level of the tempo map time warp: breakpoint table in three RAMs, a sequencer
// and a shared serial divider. Depends on tmtw_pkg, tmtw_ram and tmtw_div.
`timescale 1ns / 1ps
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  in       | in_valid / in_stall    | op, time_value, tempo_value
//  out      | out_valid / out_stall  | status, converted_time, beat_phase,
//           |                        | segment_tempo, external_tempo, tempo_bound,
//           |                        | tempo_max
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item at a time. Each table entry is read through the registered RAM read port,
// and each division runs through the serial divider. Forward and reverse walk the whole
// table; a successful add or delete also rebuilds every output time through the divider.
// With a unit_scale of zero or below, each conversion to external units and the bound
// also go through the divider.
// After reset the block loads the breakpoint at time zero before it takes an item.
// A finished result waits in the output register while the next item runs.

module tempo_map_time_warp_core #(
    parameter int MAX_POINTS = tmtw_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tmtw_pkg::OP_W-1:0]         op,
    input  logic [tmtw_pkg::TIME_W-1:0]       time_value,
    input  logic [tmtw_pkg::TEMPO_W-1:0]      tempo_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tmtw_pkg::STATUS_W-1:0]     status,
    output logic [tmtw_pkg::TIME_W-1:0]       converted_time,
    output logic [tmtw_pkg::TEMPO_W-1:0]      beat_phase,
    output logic [tmtw_pkg::TEMPO_W-1:0]      segment_tempo,
    output logic [tmtw_pkg::EXT_W-1:0]        external_tempo,
    output logic [tmtw_pkg::EXT_W-1:0]        tempo_bound,
    output logic [tmtw_pkg::TEMPO_W-1:0]      tempo_max,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tmtw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmtw_pkg::SCALE_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int TW    = tmtw_pkg::TIME_W;
    localparam int PW    = tmtw_pkg::TEMPO_W;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_TOINT_GO = 5'd1;
    localparam logic [4:0] S_TOINT_W  = 5'd2;
    localparam logic [4:0] S_TOEXT_GO = 5'd3;
    localparam logic [4:0] S_TOEXT_W  = 5'd4;
    localparam logic [4:0] S_EDIT     = 5'd5;
    localparam logic [4:0] S_ADD_RD   = 5'd6;
    localparam logic [4:0] S_ADD_US   = 5'd7;
    localparam logic [4:0] S_SH_RD    = 5'd8;
    localparam logic [4:0] S_SH_WR    = 5'd9;
    localparam logic [4:0] S_INS_WR   = 5'd10;
    localparam logic [4:0] S_DEL_RD   = 5'd11;
    localparam logic [4:0] S_DEL_US   = 5'd12;
    localparam logic [4:0] S_DSH_RD   = 5'd13;
    localparam logic [4:0] S_DSH_WR   = 5'd14;
    localparam logic [4:0] S_INIT_WR  = 5'd15;
    localparam logic [4:0] S_RB_START = 5'd16;
    localparam logic [4:0] S_RB_RD    = 5'd17;
    localparam logic [4:0] S_RB_US    = 5'd18;
    localparam logic [4:0] S_RB_W     = 5'd19;
    localparam logic [4:0] S_BOUND_GO = 5'd20;
    localparam logic [4:0] S_BOUND_W  = 5'd21;
    localparam logic [4:0] S_FWD_RD   = 5'd22;
    localparam logic [4:0] S_FWD_US   = 5'd23;
    localparam logic [4:0] S_FWD_GO   = 5'd24;
    localparam logic [4:0] S_FWD_W    = 5'd25;
    localparam logic [4:0] S_PHASE    = 5'd26;
    localparam logic [4:0] S_REV_RD   = 5'd27;
    localparam logic [4:0] S_REV_US   = 5'd28;
    localparam logic [4:0] S_REV_MUL  = 5'd29;
    localparam logic [4:0] S_REV_ADD  = 5'd30;
    localparam logic [4:0] S_RESULT   = 5'd31;

    localparam logic [1:0] K_OP    = 2'd0;
    localparam logic [1:0] K_INIT  = 2'd1;
    localparam logic [1:0] K_SCALE = 2'd2;

    logic [4:0]            state_reg, state_next;
    logic [1:0]            kind_reg, kind_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [tmtw_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [PW-1:0]         init_reg, init_next;
    logic [PW-1:0]         max_reg, max_next;
    logic [PW-1:0]         min_reg, min_next;
    logic [tmtw_pkg::EXT_W-1:0] bound_reg, bound_next;

    logic [tmtw_pkg::OP_W-1:0] op_reg, op_next;
    logic [TW-1:0]         t_reg, t_next;
    logic [PW-1:0]         tv_reg, tv_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  stop_reg, stop_next;
    logic [TW-1:0]         base_in_reg, base_in_next;
    logic [TW-1:0]         base_out_reg, base_out_next;
    logic [PW-1:0]         base_tempo_reg, base_tempo_next;
    logic [TW-1:0]         cur_in_reg, cur_in_next;
    logic [PW-1:0]         cur_tempo_reg, cur_tempo_next;
    logic [PW-1:0]         seg_reg, seg_next;
    logic [tmtw_pkg::EXT_W-1:0] ext_reg, ext_next;
    logic [TW-1:0]         conv_reg, conv_next;
    logic [PW-1:0]         phase_reg, phase_next;
    logic [tmtw_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [TW+PW-1:0]      prod_reg, prod_next;

    logic [tmtw_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [TW-1:0]         conv_out_reg, conv_out_next;
    logic [PW-1:0]         phase_out_reg, phase_out_next;
    logic [PW-1:0]         seg_out_reg, seg_out_next;
    logic [tmtw_pkg::EXT_W-1:0] ext_out_reg, ext_out_next;
    logic [tmtw_pkg::EXT_W-1:0] bound_out_reg, bound_out_next;
    logic [PW-1:0]         max_out_reg, max_out_next;

    logic [IDX_W-1:0]      raddr, waddr;
    logic                  we_in, we_out, we_tempo;
    logic [TW-1:0]         wd_in, wd_out;
    logic [PW-1:0]         wd_tempo;
    logic [TW-1:0]         rd_in, rd_out;
    logic [PW-1:0]         rd_tempo;

    tmtw_pkg::div_req_t    div_req;
    logic                  div_done;
    logic [tmtw_pkg::DIV_W-1:0] div_q;

    logic                  scale_pos;
    logic [tmtw_pkg::SCALE_W-1:0] neg_scale;
    logic [PW-1:0]         int_src;
    logic                  idx_last;
    logic [CNT_W-1:0]      idx_inc, idx_dec;
    logic [TW-1:0]         new_out;
    logic [TW+PW-17:0]     phase_prod;
    logic                  slot_free;

    assign scale_pos = !scale_reg[tmtw_pkg::SCALE_W-1] && (scale_reg != '0);
    assign neg_scale = (~scale_reg) + 24'd1;
    assign int_src   = (kind_reg == K_INIT) ? init_reg : tv_reg;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign idx_last  = (idx_inc == count_reg);
    assign new_out   = tmtw_pkg::sat_word(64'(base_out_reg) + 64'(div_q));
    assign phase_prod = conv_reg[15:0] * base_tempo_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    tmtw_ram #(.WIDTH(TW), .DEPTH(MAX_POINTS)) u_in_ram (
        .clk(clk), .we(we_in), .waddr(waddr), .wdata(wd_in), .raddr(raddr), .rdata(rd_in)
    );

    tmtw_ram #(.WIDTH(TW), .DEPTH(MAX_POINTS)) u_out_ram (
        .clk(clk), .we(we_out), .waddr(waddr), .wdata(wd_out), .raddr(raddr), .rdata(rd_out)
    );

    tmtw_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_tempo_ram (
        .clk(clk), .we(we_tempo), .waddr(waddr), .wdata(wd_tempo), .raddr(raddr),
        .rdata(rd_tempo)
    );

    tmtw_div u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        scale_next      = scale_reg;
        init_next       = init_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        bound_next      = bound_reg;
        op_next         = op_reg;
        t_next          = t_reg;
        tv_next         = tv_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        stop_next       = stop_reg;
        base_in_next    = base_in_reg;
        base_out_next   = base_out_reg;
        base_tempo_next = base_tempo_reg;
        cur_in_next     = cur_in_reg;
        cur_tempo_next  = cur_tempo_reg;
        seg_next        = seg_reg;
        ext_next        = ext_reg;
        conv_next       = conv_reg;
        phase_next      = phase_reg;
        st_next         = st_reg;
        prod_next       = prod_reg;
        status_next     = status_reg;
        conv_out_next   = conv_out_reg;
        phase_out_next  = phase_out_reg;
        seg_out_next    = seg_out_reg;
        ext_out_next    = ext_out_reg;
        bound_out_next  = bound_out_reg;
        max_out_next    = max_out_reg;

        raddr    = idx_reg[IDX_W-1:0];
        waddr    = idx_reg[IDX_W-1:0];
        we_in    = 1'b0;
        we_out   = 1'b0;
        we_tempo = 1'b0;
        wd_in    = rd_in;
        wd_out   = new_out;
        wd_tempo = rd_tempo;
        div_req  = '{start: 1'b0, dividend: '0, divisor: '0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == tmtw_pkg::REG_UNIT_SCALE)
                    begin
                        scale_next = cfg_data;
                        kind_next  = K_SCALE;
                        state_next = S_BOUND_GO;
                    end
                    else if (cfg_index == tmtw_pkg::REG_INITIAL_TEMPO)
                    begin
                        init_next  = cfg_data;
                        kind_next  = K_INIT;
                        state_next = S_TOINT_GO;
                    end
                end
                else if (in_valid)
                begin
                    op_next         = op;
                    t_next          = time_value;
                    tv_next         = tempo_value;
                    kind_next       = K_OP;
                    conv_next       = '0;
                    phase_next      = '0;
                    st_next         = tmtw_pkg::ST_OK;
                    idx_next        = '0;
                    stop_next       = 1'b0;
                    base_in_next    = '0;
                    base_out_next   = '0;
                    base_tempo_next = tmtw_pkg::ONE_TEMPO;
                    if (op == tmtw_pkg::OP_FORWARD)      state_next = S_FWD_RD;
                    else if (op == tmtw_pkg::OP_REVERSE) state_next = S_REV_RD;
                    else                                 state_next = S_TOINT_GO;
                end
            end
            S_TOINT_GO:
            begin
                if (scale_pos)
                begin
                    div_req = '{start: 1'b1, dividend: {12'd0, int_src, 12'd0},
                                divisor: {1'b0, scale_reg[tmtw_pkg::SCALE_W-2:0]}};
                    state_next = S_TOINT_W;
                end
                else if (int_src == '0)
                begin
                    seg_next   = tmtw_pkg::TEMPO_LIMIT;
                    state_next = (kind_reg == K_INIT) ? S_INIT_WR : S_TOEXT_GO;
                end
                else
                begin
                    div_req = '{start: 1'b1, dividend: {4'd0, neg_scale, 20'd0},
                                divisor: int_src};
                    state_next = S_TOINT_W;
                end
            end
            S_TOINT_W:
            begin
                if (div_done)
                begin
                    seg_next   = tmtw_pkg::clamp_tempo(div_q);
                    state_next = (kind_reg == K_INIT) ? S_INIT_WR : S_TOEXT_GO;
                end
            end
            S_TOEXT_GO:
            begin
                if (scale_pos)
                begin
                    ext_next = tmtw_pkg::scale_mul(seg_reg,
                                                   scale_reg[tmtw_pkg::SCALE_W-2:0]);
                    state_next = (op_reg == tmtw_pkg::OP_ADD ||
                                  op_reg == tmtw_pkg::OP_DELETE) ? S_EDIT : S_RESULT;
                end
                else
                begin
                    div_req = '{start: 1'b1, dividend: {4'd0, neg_scale, 20'd0},
                                divisor: seg_reg};
                    state_next = S_TOEXT_W;
                end
            end
            S_TOEXT_W:
            begin
                if (div_done)
                begin
                    ext_next   = tmtw_pkg::sat_word(64'(div_q));
                    state_next = (op_reg == tmtw_pkg::OP_ADD ||
                                  op_reg == tmtw_pkg::OP_DELETE) ? S_EDIT : S_RESULT;
                end
            end
            S_EDIT:
            begin
                idx_next = '0;
                pos_next = '0;
                if (op_reg == tmtw_pkg::OP_DELETE)
                begin
                    state_next = S_DEL_RD;
                end
                else if (count_reg == CNT_W'(MAX_POINTS))
                begin
                    st_next    = tmtw_pkg::ST_FULL;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_ADD_RD;
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_US;
            end
            S_ADD_US:
            begin
                if (rd_in <= t_reg)
                begin
                    pos_next = pos_reg + CNT_W'(1);
                end
                idx_next   = idx_inc;
                state_next = idx_last ? S_SH_RD : S_ADD_RD;
            end
            S_SH_RD:
            begin
                raddr = idx_dec[IDX_W-1:0];
                state_next = (idx_reg == pos_reg) ? S_INS_WR : S_SH_WR;
            end
            S_SH_WR:
            begin
                we_in      = 1'b1;
                we_tempo   = 1'b1;
                idx_next   = idx_dec;
                state_next = S_SH_RD;
            end
            S_INS_WR:
            begin
                waddr      = pos_reg[IDX_W-1:0];
                we_in      = 1'b1;
                we_tempo   = 1'b1;
                wd_in      = t_reg;
                wd_tempo   = seg_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RB_START;
            end
            S_DEL_RD:
            begin
                state_next = S_DEL_US;
            end
            S_DEL_US:
            begin
                if (rd_in == t_reg && rd_tempo == seg_reg)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        st_next    = tmtw_pkg::ST_LAST;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_DSH_RD;
                    end
                end
                else if (idx_last)
                begin
                    st_next    = tmtw_pkg::ST_NOT_FOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_DEL_RD;
                end
            end
            S_DSH_RD:
            begin
                raddr = idx_inc[IDX_W-1:0];
                if (idx_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RB_START;
                end
                else
                begin
                    state_next = S_DSH_WR;
                end
            end
            S_DSH_WR:
            begin
                we_in      = 1'b1;
                we_tempo   = 1'b1;
                idx_next   = idx_inc;
                state_next = S_DSH_RD;
            end
            S_INIT_WR:
            begin
                waddr      = '0;
                we_in      = 1'b1;
                we_out     = 1'b1;
                we_tempo   = 1'b1;
                wd_in      = '0;
                wd_out     = '0;
                wd_tempo   = seg_reg;
                count_next = CNT_W'(1);
                state_next = S_RB_START;
            end
            S_RB_START:
            begin
                idx_next        = '0;
                base_in_next    = '0;
                base_out_next   = '0;
                base_tempo_next = tmtw_pkg::ONE_TEMPO;
                min_next        = tmtw_pkg::TEMPO_LIMIT;
                max_next        = '0;
                state_next      = S_RB_RD;
            end
            S_RB_RD:
            begin
                state_next = S_RB_US;
            end
            S_RB_US:
            begin
                cur_in_next    = rd_in;
                cur_tempo_next = rd_tempo;
                div_req = '{start: 1'b1, dividend: {rd_in - base_in_reg, 16'd0},
                            divisor: base_tempo_reg};
                state_next = S_RB_W;
            end
            S_RB_W:
            begin
                if (div_done)
                begin
                    we_out          = 1'b1;
                    base_out_next   = new_out;
                    base_in_next    = cur_in_reg;
                    base_tempo_next = cur_tempo_reg;
                    if (cur_tempo_reg > max_reg) max_next = cur_tempo_reg;
                    if (cur_tempo_reg < min_reg) min_next = cur_tempo_reg;
                    idx_next        = idx_inc;
                    state_next      = idx_last ? S_BOUND_GO : S_RB_RD;
                end
            end
            S_BOUND_GO:
            begin
                if (scale_pos)
                begin
                    bound_next = tmtw_pkg::scale_mul(max_reg,
                                                     scale_reg[tmtw_pkg::SCALE_W-2:0]);
                    state_next = (kind_reg == K_OP) ? S_RESULT : S_IDLE;
                end
                else
                begin
                    div_req = '{start: 1'b1, dividend: {4'd0, neg_scale, 20'd0},
                                divisor: min_reg};
                    state_next = S_BOUND_W;
                end
            end
            S_BOUND_W:
            begin
                if (div_done)
                begin
                    bound_next = tmtw_pkg::sat_word(64'(div_q));
                    state_next = (kind_reg == K_OP) ? S_RESULT : S_IDLE;
                end
            end
            S_FWD_RD:
            begin
                state_next = S_FWD_US;
            end
            S_FWD_US:
            begin
                if (rd_in <= t_reg)
                begin
                    base_in_next    = rd_in;
                    base_out_next   = rd_out;
                    base_tempo_next = rd_tempo;
                end
                idx_next   = idx_inc;
                state_next = idx_last ? S_FWD_GO : S_FWD_RD;
            end
            S_FWD_GO:
            begin
                div_req = '{start: 1'b1, dividend: {t_reg - base_in_reg, 16'd0},
                            divisor: base_tempo_reg};
                state_next = S_FWD_W;
            end
            S_FWD_W:
            begin
                if (div_done)
                begin
                    conv_next  = new_out;
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                phase_next = phase_prod[TW+PW-17:16];
                seg_next   = base_tempo_reg;
                state_next = S_TOEXT_GO;
            end
            S_REV_RD:
            begin
                state_next = S_REV_US;
            end
            S_REV_US:
            begin
                if (!stop_reg)
                begin
                    if (rd_out > t_reg)
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        base_in_next    = rd_in;
                        base_out_next   = rd_out;
                        base_tempo_next = rd_tempo;
                    end
                end
                idx_next   = idx_inc;
                state_next = idx_last ? S_REV_MUL : S_REV_RD;
            end
            S_REV_MUL:
            begin
                prod_next  = (t_reg - base_out_reg) * base_tempo_reg;
                state_next = S_REV_ADD;
            end
            S_REV_ADD:
            begin
                conv_next  = tmtw_pkg::sat_word(64'(base_in_reg) +
                                                64'(prod_reg[TW+PW-1:16]));
                seg_next   = base_tempo_reg;
                state_next = S_TOEXT_GO;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    conv_out_next  = conv_reg;
                    phase_out_next = phase_reg;
                    seg_out_next   = seg_reg;
                    ext_out_next   = ext_reg;
                    bound_out_next = bound_reg;
                    max_out_next   = max_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_TOINT_GO;
            kind_reg      <= K_INIT;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
            scale_reg     <= tmtw_pkg::UNIT_SCALE_RESET;
            init_reg      <= tmtw_pkg::INITIAL_TEMPO_RESET;
            max_reg       <= '0;
            min_reg       <= tmtw_pkg::TEMPO_LIMIT;
            bound_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            scale_reg     <= scale_next;
            init_reg      <= init_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            bound_reg     <= bound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        t_reg          <= t_next;
        tv_reg         <= tv_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        stop_reg       <= stop_next;
        base_in_reg    <= base_in_next;
        base_out_reg   <= base_out_next;
        base_tempo_reg <= base_tempo_next;
        cur_in_reg     <= cur_in_next;
        cur_tempo_reg  <= cur_tempo_next;
        seg_reg        <= seg_next;
        ext_reg        <= ext_next;
        conv_reg       <= conv_next;
        phase_reg      <= phase_next;
        st_reg         <= st_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        conv_out_reg   <= conv_out_next;
        phase_out_reg  <= phase_out_next;
        seg_out_reg    <= seg_out_next;
        ext_out_reg    <= ext_out_next;
        bound_out_reg  <= bound_out_next;
        max_out_reg    <= max_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign converted_time = conv_out_reg;
    assign beat_phase     = phase_out_reg;
    assign segment_tempo  = seg_out_reg;
    assign external_tempo = ext_out_reg;
    assign tempo_bound    = bound_out_reg;
    assign tempo_max      = max_out_reg;

endmodule

/* src/tmtw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module tmtw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/tmtw_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on tmtw_pkg.
`timescale 1ns / 1ps

module tmtw_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tmtw_pkg::div_req_t               req,
    output logic                             done,
    output logic [tmtw_pkg::DIV_W-1:0]       quotient
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [tmtw_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tmtw_pkg::TEMPO_W-1:0]       rem_reg, rem_next;
    logic [tmtw_pkg::DIV_W-1:0]         quo_reg, quo_next;
    logic [tmtw_pkg::TEMPO_W-1:0]       dvs_reg, dvs_next;
    logic [tmtw_pkg::TEMPO_W:0]         rem_shift;
    logic [tmtw_pkg::TEMPO_W+1:0]       diff;
    logic                               ge;

    assign rem_shift = {rem_reg, quo_reg[tmtw_pkg::DIV_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign ge        = !diff[tmtw_pkg::TEMPO_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[tmtw_pkg::TEMPO_W-1:0] : rem_shift[tmtw_pkg::TEMPO_W-1:0];
            quo_next = {quo_reg[tmtw_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tmtw_pkg::DIV_CNT_W'(tmtw_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sim/tempo_map_time_warp_core_tb.sv */
// Self-checking testbench for tempo_map_time_warp_core: a scoreboard class predicts every
// result from its own copy of the tempo table. Depends on tmtw_pkg and the RTL under src.
`timescale 1ns / 1ps

module tempo_map_time_warp_core_tb;

    localparam int TABLE_DEPTH = tmtw_pkg::MAX_POINTS_DEF;

    typedef struct packed {
        logic [tmtw_pkg::STATUS_W-1:0] status;
        logic [tmtw_pkg::TIME_W-1:0]   converted_time;
        logic [tmtw_pkg::TEMPO_W-1:0]  beat_phase;
        logic [tmtw_pkg::TEMPO_W-1:0]  segment_tempo;
        logic [tmtw_pkg::EXT_W-1:0]    external_tempo;
        logic [tmtw_pkg::EXT_W-1:0]    tempo_bound;
        logic [tmtw_pkg::TEMPO_W-1:0]  tempo_max;
    } warp_result_t;

    class warp_scoreboard;
        logic [tmtw_pkg::TIME_W-1:0]  in_time [TABLE_DEPTH];
        logic [tmtw_pkg::TIME_W-1:0]  out_time [TABLE_DEPTH];
        logic [tmtw_pkg::TEMPO_W-1:0] tempo [TABLE_DEPTH];
        int                           count;
        logic [tmtw_pkg::TEMPO_W-1:0] max_tempo;
        logic [tmtw_pkg::EXT_W-1:0]   bound;
        logic signed [tmtw_pkg::SCALE_W-1:0] scale;
        logic [tmtw_pkg::TEMPO_W-1:0] init_tempo;
        warp_result_t                 expected_q[$];
        int                           mismatches;

        function new();
            scale = tmtw_pkg::UNIT_SCALE_RESET;
            init_tempo = tmtw_pkg::INITIAL_TEMPO_RESET;
            mismatches = 0;
            load_origin();
        endfunction

        function logic [tmtw_pkg::EXT_W-1:0] clip_word(longint unsigned v);
            return (v > 64'hFFFFFFFF) ? tmtw_pkg::WORD_LIMIT : v[31:0];
        endfunction

        function longint unsigned neg_scale();
            longint signed s;
            s = scale;
            return longint'(-s);
        endfunction

        function logic [tmtw_pkg::TEMPO_W-1:0] ext_to_int(logic [tmtw_pkg::TEMPO_W-1:0] ext);
            longint unsigned r;
            if (scale > 0)
                r = (longint'(ext) << 12) / longint'(scale);
            else if (ext == 0)
                r = tmtw_pkg::TEMPO_LIMIT;
            else
                r = (neg_scale() << 20) / longint'(ext);
            if (r > tmtw_pkg::TEMPO_LIMIT) r = tmtw_pkg::TEMPO_LIMIT;
            if (r < 1) r = 1;
            return r[tmtw_pkg::TEMPO_W-1:0];
        endfunction

        function logic [tmtw_pkg::EXT_W-1:0] int_to_ext(logic [tmtw_pkg::TEMPO_W-1:0] t);
            if (scale <= 0)
                return clip_word((neg_scale() << 20) / longint'(t));
            return clip_word((longint'(t) * longint'(scale)) >> 12);
        endfunction

        function void update_bound();
            logic [tmtw_pkg::TEMPO_W-1:0] lo, hi;
            lo = tmtw_pkg::TEMPO_LIMIT;
            hi = 0;
            for (int i = 0; i < count; i++)
            begin
                if (tempo[i] > hi) hi = tempo[i];
                if (tempo[i] < lo) lo = tempo[i];
            end
            if (lo < 1) lo = 1;
            max_tempo = hi;
            if (scale <= 0) bound = clip_word((neg_scale() << 20) / longint'(lo));
            else bound = clip_word((longint'(hi) * longint'(scale)) >> 12);
        endfunction

        function void rebuild_out_times();
            logic [tmtw_pkg::TIME_W-1:0] in_prev, out_prev, delta;
            logic [tmtw_pkg::TEMPO_W-1:0] t;
            in_prev = 0;
            out_prev = 0;
            t = tmtw_pkg::ONE_TEMPO;
            for (int i = 0; i < count; i++)
            begin
                delta = in_time[i] - in_prev;
                out_time[i] = clip_word(longint'(out_prev)
                                        + ((longint'(delta) << 16) / longint'(t)));
                in_prev = in_time[i];
                out_prev = out_time[i];
                t = tempo[i];
            end
            update_bound();
        endfunction

        function void load_origin();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                in_time[i] = 0;
                out_time[i] = 0;
                tempo[i] = 0;
            end
            count = 1;
            tempo[0] = ext_to_int(init_tempo);
            rebuild_out_times();
        endfunction

        function void write_register(logic [tmtw_pkg::CFG_IDX_W-1:0] idx,
                                     logic [tmtw_pkg::SCALE_W-1:0] data);
            if (idx == tmtw_pkg::REG_UNIT_SCALE)
            begin
                scale = data;
                update_bound();
            end
            else if (idx == tmtw_pkg::REG_INITIAL_TEMPO)
            begin
                init_tempo = data;
                load_origin();
            end
        endfunction

        function void note_item(logic [tmtw_pkg::OP_W-1:0] op, logic [tmtw_pkg::TIME_W-1:0] t,
                                logic [tmtw_pkg::TEMPO_W-1:0] tv);
            warp_result_t r;
            int pos;
            logic [tmtw_pkg::TIME_W-1:0] base_in, base_out;
            logic [tmtw_pkg::TEMPO_W-1:0] seg;
            r = '0;
            if (op == tmtw_pkg::OP_ADD || op == tmtw_pkg::OP_DELETE)
            begin
                r.segment_tempo = ext_to_int(tv);
                r.external_tempo = int_to_ext(r.segment_tempo);
                if (op == tmtw_pkg::OP_ADD)
                begin
                    if (count >= TABLE_DEPTH) r.status = tmtw_pkg::ST_FULL;
                    else
                    begin
                        pos = 0;
                        while (pos < count && in_time[pos] <= t) pos++;
                        for (int i = count; i > pos; i--)
                        begin
                            in_time[i] = in_time[i-1];
                            tempo[i] = tempo[i-1];
                        end
                        in_time[pos] = t;
                        tempo[pos] = r.segment_tempo;
                        count++;
                        rebuild_out_times();
                    end
                end
                else
                begin
                    pos = -1;
                    for (int i = 0; i < count; i++)
                        if (pos < 0 && in_time[i] == t && tempo[i] == r.segment_tempo)
                            pos = i;
                    if (pos < 0) r.status = tmtw_pkg::ST_NOT_FOUND;
                    else if (count <= 1) r.status = tmtw_pkg::ST_LAST;
                    else
                    begin
                        for (int i = pos; i + 1 < count; i++)
                        begin
                            in_time[i] = in_time[i+1];
                            tempo[i] = tempo[i+1];
                        end
                        in_time[count-1] = 0;
                        out_time[count-1] = 0;
                        tempo[count-1] = 0;
                        count--;
                        rebuild_out_times();
                    end
                end
            end
            else
            begin
                base_in = 0;
                base_out = 0;
                seg = tmtw_pkg::ONE_TEMPO;
                if (op == tmtw_pkg::OP_FORWARD)
                begin
                    for (int i = 0; i < count; i++)
                        if (in_time[i] <= t)
                        begin
                            base_in = in_time[i];
                            base_out = out_time[i];
                            seg = tempo[i];
                        end
                    r.converted_time = clip_word(longint'(base_out)
                        + ((longint'(tmtw_pkg::TIME_W'(t - base_in)) << 16) / longint'(seg)));
                    r.beat_phase = tmtw_pkg::TEMPO_W'(
                        (longint'(r.converted_time[15:0]) * longint'(seg)) >> 16);
                end
                else
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        if (out_time[i] > t) break;
                        base_in = in_time[i];
                        base_out = out_time[i];
                        seg = tempo[i];
                    end
                    r.converted_time = clip_word(longint'(base_in)
                        + ((longint'(tmtw_pkg::TIME_W'(t - base_out)) * longint'(seg)) >> 16));
                end
                r.segment_tempo = seg;
                r.external_tempo = int_to_ext(seg);
            end
            r.tempo_bound = bound;
            r.tempo_max = max_tempo;
            expected_q.push_back(r);
        endfunction

        function void check_result(warp_result_t got);
            warp_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat: %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic                           clk = 0;
    logic                           rst_n = 0;
    logic                           in_valid = 0;
    logic                           in_stall;
    logic [tmtw_pkg::OP_W-1:0]      op = tmtw_pkg::OP_FORWARD;
    logic [tmtw_pkg::TIME_W-1:0]    time_value = 0;
    logic [tmtw_pkg::TEMPO_W-1:0]   tempo_value = 24'd1;
    logic                           out_valid;
    logic                           out_stall = 0;
    warp_result_t                   dut_result;
    logic                           cfg_valid = 0;
    logic                           cfg_ready;
    logic [tmtw_pkg::CFG_IDX_W-1:0] cfg_index = tmtw_pkg::REG_UNIT_SCALE;
    logic [tmtw_pkg::SCALE_W-1:0]   cfg_data = 0;

    warp_scoreboard                 sb = new();
    int                             send_idle_pct = 0;
    int                             recv_stall_pct = 0;
    int                             hold_request = 0;
    int                             hold_left = 0;
    logic [tmtw_pkg::TIME_W-1:0]    edit_times[$];
    logic [tmtw_pkg::TEMPO_W-1:0]   edit_tempos[$];

    always #5 clk = ~clk;

    tempo_map_time_warp_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .time_value(time_value), .tempo_value(tempo_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(dut_result.status), .converted_time(dut_result.converted_time),
        .beat_phase(dut_result.beat_phase), .segment_tempo(dut_result.segment_tempo),
        .external_tempo(dut_result.external_tempo), .tempo_bound(dut_result.tempo_bound),
        .tempo_max(dut_result.tempo_max),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(dut_result);
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_item(input logic [tmtw_pkg::OP_W-1:0] o,
                             input logic [tmtw_pkg::TIME_W-1:0] t,
                             input logic [tmtw_pkg::TEMPO_W-1:0] tv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        time_value <= t;
        tempo_value <= tv;
        do @(posedge clk); while (in_stall);
        sb.note_item(o, t, tv);
        if (o == tmtw_pkg::OP_ADD)
        begin
            edit_times.push_back(t);
            edit_tempos.push_back(tv);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(input logic [tmtw_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tmtw_pkg::SCALE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_register(idx, data);
    endtask

    task automatic send_random();
        int pick, k;
        logic [tmtw_pkg::TIME_W-1:0] t;
        logic [tmtw_pkg::TEMPO_W-1:0] tv;
        pick = $urandom_range(99);
        t = ($urandom_range(9) < 7) ? tmtw_pkg::TIME_W'($urandom_range(63)) << 15 : $urandom;
        case ($urandom_range(3))
            0: tv = tmtw_pkg::TEMPO_W'($urandom);
            1: tv = tmtw_pkg::TEMPO_W'($urandom_range(8)) << 15;
            default: tv = tmtw_pkg::TEMPO_W'($urandom_range(4096, 400000));
        endcase
        if (pick < 30) send_item(tmtw_pkg::OP_ADD, t, tv);
        else if (pick < 55)
        begin
            if (edit_times.size() != 0 && $urandom_range(9) < 8)
            begin
                k = $urandom_range(edit_times.size() - 1);
                send_item(tmtw_pkg::OP_DELETE, edit_times[k], edit_tempos[k]);
                edit_times.delete(k);
                edit_tempos.delete(k);
            end
            else send_item(tmtw_pkg::OP_DELETE, t, tv);
        end
        else if (pick < 80) send_item(tmtw_pkg::OP_FORWARD, t, tv);
        else send_item(tmtw_pkg::OP_REVERSE, t, tv);
    endtask

    initial
    begin
        logic signed [tmtw_pkg::SCALE_W-1:0] scales[6];
        logic [tmtw_pkg::TEMPO_W-1:0] inits[6];
        scales = '{24'sd4096, 24'sd8388607, -24'sd8388608, 24'sd0, -24'sd4096, 24'sd1};
        inits = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd300000, 24'd65536, 24'd12345};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_item(tmtw_pkg::OP_DELETE, 0, 24'd65536);
        send_item(tmtw_pkg::OP_DELETE, 5, 24'd65536);
        send_item(tmtw_pkg::OP_FORWARD, 0, 0);
        send_item(tmtw_pkg::OP_FORWARD, 32'hFFFFFFFF, 24'hFFFFFF);
        send_item(tmtw_pkg::OP_REVERSE, 0, 24'd1);
        send_item(tmtw_pkg::OP_REVERSE, 32'hFFFFFFFF, 24'd1);
        send_item(tmtw_pkg::OP_ADD, 0, 24'd1);
        send_item(tmtw_pkg::OP_ADD, 32'hFFFFFFFF, 24'hFFFFFF);
        send_item(tmtw_pkg::OP_ADD, 32'h00010000, 24'd0);
        send_item(tmtw_pkg::OP_FORWARD, 32'h00008000, 24'd1);
        send_item(tmtw_pkg::OP_REVERSE, 32'h80000000, 24'd1);
        for (int i = 0; i < 13; i++)
            send_item(tmtw_pkg::OP_ADD, tmtw_pkg::TIME_W'(i) << 14,
                      tmtw_pkg::TEMPO_W'($urandom_range(1, 24'hFFFFFF)));
        send_item(tmtw_pkg::OP_ADD, 32'h00020000, 24'd65536);
        send_item(tmtw_pkg::OP_DELETE, 32'hFFFFFFFF, 24'hFFFFFF);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 61 : 0;
            recv_stall_pct = (ph < 2) ? 61 : (ph < 4) ? 14 : 0;
            write_register(tmtw_pkg::REG_UNIT_SCALE, scales[ph]);
            write_register(tmtw_pkg::REG_INITIAL_TEMPO, inits[ph]);
            edit_times.delete();
            edit_tempos.delete();
            for (int n = 0; n < 205; n++)
            begin
                if (ph == 1 && n == 100) hold_request = 3000;
                if (ph == 3 && n == 100) drain();
                send_random();
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
src/tmtw_pkg.sv
src/tmtw_ram.sv
src/tmtw_div.sv
src/tempo_map_time_warp_core.sv
sim/tempo_map_time_warp_core_tb.sv
